[hdl/complex_arithmetic_unit_macros.svh]
// Assertion macros shared by the complex arithmetic unit.
// Each macro expects clk and rst (synchronous, active high) in scope.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define CAU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("complex_arithmetic_unit: check failed");

// Consequent must hold in the cycle after the antecedent
`define CAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("complex_arithmetic_unit: check failed");

`endif

[hdl/cau_pkg.sv]
// Shared types for the complex arithmetic unit.
// Opcodes, the per-item control word and the divider state encoding.
`timescale 1ns / 1ps

package cau_pkg;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_SCALE = 3'd4,
    OP_DIVR  = 3'd5,
    OP_CONJ  = 3'd6,
    OP_ROT   = 3'd7
  } op_t;

  // Classification made by the front end
  typedef struct packed {
    op_t  op;
    logic zero;   // divisor is zero for a divide opcode
  } ctrl_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

endpackage

[hdl/cau_front.sv]
// Front end: accepts items, classifies divide-by-zero, and pushes into the queue.
// Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid,
  output logic                         stall,
  input  logic [2:0]                   op,
  input  logic signed [DATA_WIDTH-1:0] a_re,
  input  logic signed [DATA_WIDTH-1:0] a_im,
  input  logic signed [DATA_WIDTH-1:0] b_re,
  input  logic signed [DATA_WIDTH-1:0] b_im,
  input  logic signed [DATA_WIDTH-1:0] scalar,
  input  logic                         fifo_full,
  output logic                         push,
  output logic [5*DATA_WIDTH+$bits(cau_pkg::ctrl_t)-1:0] push_data
);

  localparam int DW = 5 * DATA_WIDTH + $bits(cau_pkg::ctrl_t);

  logic          f_v;
  logic [DW-1:0] f_data;
  logic          ready;
  cau_pkg::ctrl_t ctrl;

  // Classify the opcode and flag a zero divisor
  always_comb begin
    ctrl.op   = cau_pkg::op_t'(op);
    ctrl.zero = 1'b0;
    case (ctrl.op)
      cau_pkg::OP_DIV:  ctrl.zero = (b_re == '0) && (b_im == '0);
      cau_pkg::OP_DIVR: ctrl.zero = (scalar == '0);
      default:          ctrl.zero = 1'b0;
    endcase
  end

  assign ready     = !f_v || !fifo_full;
  assign stall     = !ready;
  assign push      = f_v && !fifo_full;
  assign push_data = f_data;

  // Hold one classified item ahead of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (ready) begin
      f_v <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (valid && ready) begin
      f_data <= {ctrl, a_re, a_im, b_re, b_im, scalar};
    end
  end

endmodule

[hdl/cau_fifo.sv]
// Short item queue between front end and back end.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module cau_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = mem[rd_ptr];

  // Store item at write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/cau_div.sv]
// Radix-2 restoring divider for both result components, one quotient bit per cycle.
// Depends on cau_pkg; saturates quotients to DATA_WIDTH.
`timescale 1ns / 1ps

module cau_div #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [2*DATA_WIDTH:0]     n_re,
  input  logic signed [2*DATA_WIDTH:0]     n_im,
  input  logic [2*DATA_WIDTH-1:0]          den,
  input  logic                             ack,
  output logic                             idle,
  output logic                             done,
  output logic signed [DATA_WIDTH-1:0]     q_re,
  output logic signed [DATA_WIDTH-1:0]     q_im,
  output logic                             ov
);

  localparam int NW = 2 * DATA_WIDTH + 1;
  localparam int QW = NW + FRAC_BITS;
  localparam int PW = 2 * DATA_WIDTH;
  localparam int RW = PW + 1;
  localparam int CW = $clog2(QW + 1);
  localparam logic [QW-1:0] MAXP = QW'({(DATA_WIDTH-1){1'b1}});
  localparam logic [QW-1:0] MAXN = MAXP + 1'b1;

  cau_pkg::div_state_t state, state_next;

  logic [QW-1:0] qn_re, qn_im;
  logic [RW-1:0] rem_re, rem_im;
  logic [PW-1:0] d;
  logic [CW-1:0] cnt;
  logic          neg_re, neg_im;
  logic [NW-1:0] mag_re, mag_im;
  logic [RW-1:0] tr_re, tr_im;
  logic          ge_re, ge_im;
  logic [QW-1:0] negq_re, negq_im;
  logic          ov_re, ov_im;

  assign mag_re = n_re[NW-1] ? NW'(-n_re) : NW'(n_re);
  assign mag_im = n_im[NW-1] ? NW'(-n_im) : NW'(n_im);

  // One restoring step per component
  assign tr_re = {rem_re[RW-2:0], qn_re[QW-1]};
  assign tr_im = {rem_im[RW-2:0], qn_im[QW-1]};
  assign ge_re = (tr_re >= {1'b0, d});
  assign ge_im = (tr_im >= {1'b0, d});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cau_pkg::DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    idle       = 1'b0;
    done       = 1'b0;
    case (state)
      cau_pkg::DIV_IDLE: begin
        idle = 1'b1;
        if (start) state_next = cau_pkg::DIV_RUN;
      end
      cau_pkg::DIV_RUN: begin
        if (cnt == CW'(1)) state_next = cau_pkg::DIV_DONE;
      end
      cau_pkg::DIV_DONE: begin
        done = 1'b1;
        if (ack) state_next = cau_pkg::DIV_IDLE;
      end
      default: state_next = cau_pkg::DIV_IDLE;
    endcase
  end

  // Load operands, then shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (state == cau_pkg::DIV_IDLE && start) begin
      qn_re  <= QW'(mag_re) << FRAC_BITS;
      qn_im  <= QW'(mag_im) << FRAC_BITS;
      rem_re <= '0;
      rem_im <= '0;
      d      <= den;
      neg_re <= n_re[NW-1];
      neg_im <= n_im[NW-1];
      cnt    <= CW'(QW);
    end else if (state == cau_pkg::DIV_RUN) begin
      rem_re <= ge_re ? tr_re - {1'b0, d} : tr_re;
      rem_im <= ge_im ? tr_im - {1'b0, d} : tr_im;
      qn_re  <= {qn_re[QW-2:0], ge_re};
      qn_im  <= {qn_im[QW-2:0], ge_im};
      cnt    <= cnt - 1'b1;
    end
  end

  // Apply sign and saturate
  assign negq_re = -qn_re;
  assign negq_im = -qn_im;

  always_comb begin
    ov_re = 1'b0;
    ov_im = 1'b0;
    if (neg_re) begin
      ov_re = (qn_re > MAXN);
      q_re  = ov_re ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : negq_re[DATA_WIDTH-1:0];
    end else begin
      ov_re = (qn_re > MAXP);
      q_re  = ov_re ? {1'b0, {(DATA_WIDTH-1){1'b1}}} : qn_re[DATA_WIDTH-1:0];
    end
    if (neg_im) begin
      ov_im = (qn_im > MAXN);
      q_im  = ov_im ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : negq_im[DATA_WIDTH-1:0];
    end else begin
      ov_im = (qn_im > MAXP);
      q_im  = ov_im ? {1'b0, {(DATA_WIDTH-1){1'b1}}} : qn_im[DATA_WIDTH-1:0];
    end
    ov = ov_re || ov_im;
  end

endmodule

[hdl/cau_back.sv]
// Back end: product stage, combine stage, shared divider and result register.
// Depends on cau_pkg, cau_div and the assertion macro header.
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_macros.svh"

module cau_back #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [5*DATA_WIDTH+$bits(cau_pkg::ctrl_t)-1:0] head,
  input  logic                         empty,
  output logic                         pop,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic signed [DATA_WIDTH-1:0] res_re,
  output logic signed [DATA_WIDTH-1:0] res_im,
  output logic                         div_zero,
  output logic                         overflow
);

  localparam int W  = DATA_WIDTH;
  localparam int P  = 2 * W;
  localparam int NW = 2 * W + 1;
  localparam int X  = 2 * W + 2;
  localparam logic signed [X-1:0] MAXV = {{(X-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [X-1:0] MINV = {{(X-W+1){1'b1}}, {(W-1){1'b0}}};

  // Unpack queue head
  cau_pkg::ctrl_t      h_ctrl;
  logic signed [W-1:0] h_ar, h_ai, h_br, h_bi, h_s;
  logic signed [W-1:0] x0;

  assign {h_ctrl, h_ar, h_ai, h_br, h_bi, h_s} = head;
  assign x0 = (h_ctrl.op == cau_pkg::OP_SCALE) ? h_s : h_br;

  // Stage 1: products
  logic                s1_v;
  cau_pkg::ctrl_t      s1_ctrl;
  logic signed [P-1:0] s1_p0, s1_p1, s1_p2, s1_p3, s1_q0, s1_q1;
  logic signed [W-1:0] s1_ar, s1_ai, s1_br, s1_bi, s1_s;

  // Stage 2: combined values
  logic                s2_v;
  logic                s2_isdiv;
  logic                s2_dz;
  logic signed [X-1:0] s2_re, s2_im;
  logic [P-1:0]        s2_den;

  logic signed [X-1:0] c_re, c_im;
  logic [P-1:0]        c_den;
  logic                c_isdiv;
  logic [W-1:0]        abs_s;

  logic div_idle, div_done, div_ov;
  logic signed [W-1:0] div_re, div_im;

  logic out_ready, div_take, s2_take, s2_start, s2_free, s1_free;
  logic signed [W-1:0] sat_re, sat_im;
  logic                sat_ov_re, sat_ov_im;

  // Handshake between stages
  assign out_ready = !res_valid || !res_stall;
  assign div_take  = div_done && out_ready;
  assign s2_take   = s2_v && !s2_isdiv && div_idle && out_ready;
  assign s2_start  = s2_v && s2_isdiv && div_idle;
  assign s2_free   = !s2_v || s2_take || s2_start;
  assign s1_free   = !s1_v || s2_free;
  assign pop       = !empty && s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_free) begin
      s1_v <= !empty;
    end
  end

  // Form products for the head item
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_ctrl <= h_ctrl;
      s1_p0   <= h_ar * x0;
      s1_p1   <= h_ai * h_bi;
      s1_p2   <= h_ai * x0;
      s1_p3   <= h_ar * h_bi;
      s1_q0   <= h_br * h_br;
      s1_q1   <= h_bi * h_bi;
      s1_ar   <= h_ar;
      s1_ai   <= h_ai;
      s1_br   <= h_br;
      s1_bi   <= h_bi;
      s1_s    <= h_s;
    end
  end

  assign abs_s = s1_s[W-1] ? W'(-s1_s) : W'(s1_s);

  // Combine products per opcode
  always_comb begin
    c_re    = '0;
    c_im    = '0;
    c_den   = '0;
    c_isdiv = 1'b0;
    case (s1_ctrl.op)
      cau_pkg::OP_ADD: begin
        c_re = X'(s1_ar) + X'(s1_br);
        c_im = X'(s1_ai) + X'(s1_bi);
      end
      cau_pkg::OP_SUB: begin
        c_re = X'(s1_ar) - X'(s1_br);
        c_im = X'(s1_ai) - X'(s1_bi);
      end
      cau_pkg::OP_MUL: begin
        c_re = (X'(s1_p0) - X'(s1_p1)) >>> FRAC_BITS;
        c_im = (X'(s1_p2) + X'(s1_p3)) >>> FRAC_BITS;
      end
      cau_pkg::OP_DIV: begin
        c_re    = X'(s1_p0) + X'(s1_p1);
        c_im    = X'(s1_p2) - X'(s1_p3);
        c_den   = $unsigned(s1_q0) + $unsigned(s1_q1);
        c_isdiv = !s1_ctrl.zero;
      end
      cau_pkg::OP_SCALE: begin
        c_re = X'(s1_p0) >>> FRAC_BITS;
        c_im = X'(s1_p2) >>> FRAC_BITS;
      end
      cau_pkg::OP_DIVR: begin
        // Fold the scalar's sign into the numerator; the divider sees |scalar|
        c_re    = s1_s[W-1] ? -X'(s1_ar) : X'(s1_ar);
        c_im    = s1_s[W-1] ? -X'(s1_ai) : X'(s1_ai);
        c_den   = P'(abs_s);
        c_isdiv = !s1_ctrl.zero;
      end
      cau_pkg::OP_CONJ: begin
        c_re = X'(s1_ar);
        c_im = -X'(s1_ai);
      end
      cau_pkg::OP_ROT: begin
        c_re = -X'(s1_ai);
        c_im = X'(s1_ar);
      end
      default: begin
        c_re = '0;
        c_im = '0;
      end
    endcase
    if (s1_ctrl.zero) begin
      c_re = '0;
      c_im = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_free) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v && s2_free) begin
      s2_re    <= c_re;
      s2_im    <= c_im;
      s2_den   <= c_den;
      s2_isdiv <= c_isdiv;
      s2_dz    <= s1_ctrl.zero;
    end
  end

  cau_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (s2_start),
    .n_re  (NW'(s2_re)),
    .n_im  (NW'(s2_im)),
    .den   (s2_den),
    .ack   (div_take),
    .idle  (div_idle),
    .done  (div_done),
    .q_re  (div_re),
    .q_im  (div_im),
    .ov    (div_ov)
  );

  // Saturate non-divide results
  always_comb begin
    sat_ov_re = (s2_re > MAXV) || (s2_re < MINV);
    sat_ov_im = (s2_im > MAXV) || (s2_im < MINV);
    if (s2_re > MAXV)      sat_re = MAXV[W-1:0];
    else if (s2_re < MINV) sat_re = MINV[W-1:0];
    else                   sat_re = s2_re[W-1:0];
    if (s2_im > MAXV)      sat_im = MAXV[W-1:0];
    else if (s2_im < MINV) sat_im = MINV[W-1:0];
    else                   sat_im = s2_im[W-1:0];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_ready) begin
      res_valid <= div_take || s2_take;
    end
  end

  always_ff @(posedge clk) begin
    if (div_take) begin
      res_re   <= div_re;
      res_im   <= div_im;
      div_zero <= 1'b0;
      overflow <= div_ov;
    end else if (s2_take) begin
      res_re   <= sat_re;
      res_im   <= sat_im;
      div_zero <= s2_dz;
      overflow <= sat_ov_re || sat_ov_im;
    end
  end

  `CAU_ASSERT_NEXT(a_div_keeps_item, !div_idle && !div_done, !div_idle)
  `CAU_ASSERT_NEXT(a_s1_holds, s1_v && !s2_free, s1_v)
  `CAU_ASSERT_SAME(a_dz_clean, res_valid && div_zero, res_re == '0 && res_im == '0 && !overflow)

endmodule

[hdl/complex_arithmetic_unit.sv]
// Complex fixed-point ALU: add, sub, mul, div, scale, divide by real, conj, times i.
// Non-divide items stream at one per cycle while res_stall is low and the divider is idle;
// divide items run through one shared radix-2 divider that produces one quotient
// bit per cycle. Each divide loads its operands, shifts in its quotient bits and
// hands its result to the result register, and later items wait behind it to keep
// results in order. Numbers are Q15.16 at the default parameters. A four-entry
// queue sits between the front end and the back end. Results saturate and set
// overflow; a zero divisor returns zero with div_zero set. Depends on cau_pkg and
// submodules.
`timescale 1ns / 1ps

module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid,
  output logic                         stall,
  input  logic [2:0]                   op,
  input  logic signed [DATA_WIDTH-1:0] a_re,
  input  logic signed [DATA_WIDTH-1:0] a_im,
  input  logic signed [DATA_WIDTH-1:0] b_re,
  input  logic signed [DATA_WIDTH-1:0] b_im,
  input  logic signed [DATA_WIDTH-1:0] scalar,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic signed [DATA_WIDTH-1:0] res_re,
  output logic signed [DATA_WIDTH-1:0] res_im,
  output logic                         div_zero,
  output logic                         overflow
);

  localparam int ItemW = 5 * DATA_WIDTH + $bits(cau_pkg::ctrl_t);
  localparam int Depth = 4;

  logic             push, pop, empty, full;
  logic [ItemW-1:0] push_data, head;

  cau_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .valid     (valid),
    .stall     (stall),
    .op        (op),
    .a_re      (a_re),
    .a_im      (a_im),
    .b_re      (b_re),
    .b_im      (b_im),
    .scalar    (scalar),
    .fifo_full (full),
    .push      (push),
    .push_data (push_data)
  );

  cau_fifo #(
    .WIDTH (ItemW),
    .DEPTH (Depth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  cau_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_re    (res_re),
    .res_im    (res_im),
    .div_zero  (div_zero),
    .overflow  (overflow)
  );

endmodule
